// ----- design/tcp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, state codes and helpers for the two-level coordinate partitioner.
// No dependencies.
package tcp_pkg;

	localparam int MAX_CELLS   = 1024;
	localparam int MAX_PARTS_X = 16;
	localparam int MAX_PARTS_Y = 16;
	localparam int CELL_W      = 10;
	localparam int CNT_W       = 11;
	localparam int KEY_W       = 34;
	localparam int PART_W      = 8;
	localparam int SLICE_W     = 4;
	localparam int PARTS_W     = 5;
	localparam int POS_W       = 12;

	localparam logic REG_PARTS_X = 1'b0;
	localparam logic REG_PARTS_Y = 1'b1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_MISS = 1'b1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_DIV   = 12'b0000_0000_0010,
		S_XA    = 12'b0000_0000_0100,
		S_XK    = 12'b0000_0000_1000,
		S_XSCAN = 12'b0000_0001_0000,
		S_SA    = 12'b0000_0010_0000,
		S_SL    = 12'b0000_0100_0000,
		S_SSRCH = 12'b0000_1000_0000,
		S_YA    = 12'b0001_0000_0000,
		S_YK    = 12'b0010_0000_0000,
		S_YSCAN = 12'b0100_0000_0000,
		S_PSRCH = 12'b1000_0000_0000
	} state_t;

	// 0 acts as 1, anything above the maximum acts as the maximum
	function automatic logic [PARTS_W-1:0] clamp_parts(logic [PARTS_W-1:0] v,
		logic [PARTS_W-1:0] mx);
		logic [PARTS_W-1:0] r;
		r = v;
		if (v == '0) r = PARTS_W'(1);
		else if (v > mx) r = mx;
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] sext(logic [31:0] v);
		return {{(KEY_W-32){v[31]}}, v};
	endfunction

endpackage

// ----- design/two_level_coordinate_partition_top.sv -----
`timescale 1ns / 1ps
// Query result: a query transfer sets rd_pend_q, which then sets the tvalid register; one item at a time.
// A load marked last starts partitioning: the divider finds q = n/px, then (q+1)/py and q/py;
// then an x rank pass and a slice lookup per cell, then a y rank pass and a piece lookup per cell
// (rank passes issue one read a cycle); no item is taken meanwhile.
// Reset (arst_n, asynchronous): idle, no cells loaded, parts_x = parts_y = 1; stores undefined.
// Top level of the partitioner; depends on tcp_pkg.
module two_level_coordinate_partition_top
	import tcp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3 (32 each), query_cell (10), zero pad (6)
	input  logic [271:0] s_tdata,
	// mode
	input  logic         s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// partition (8)
	output logic [7:0]   m_tdata,
	// status
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t state_q;
	logic [PARTS_W-1:0] px_q, py_q, pxc, pyc;
	logic [CNT_W-1:0] count_q, n_q, ce;
	logic done_q;
	logic [1:0] dv_ph_q;
	logic [CNT_W-1:0] acc_q, quo_q, qx_q, qq1_q, qq0_q;
	logic [PARTS_W-1:0] rx_q, rr1_q, rr0_q, dvs;
	logic [CNT_W-1:0] a_q, b_q;
	logic v_s1;
	logic [CELL_W-1:0] b_s1, cnt_q, t_q;
	logic signed [KEY_W-1:0] ka_q;
	logic [SLICE_W-1:0] sa_q, k_q;
	logic [POS_W-1:0] st_q, nxt_s, nxt_p;
	logic rd_pend_q, pend_st_q;
	logic m_tvalid_q, status_q;
	logic [PART_W-1:0] part_q;

	logic in_xfer, ld_xfer, q_xfer, last_a, big;
	logic [CELL_W-1:0] rd_addr;
	logic signed [KEY_W-1:0] xsum, ysum, xrd, yrd, key_b;
	logic [CELL_W-1:0] ord_rd, ord_wd;
	logic [PART_W-1:0] pm_rd;
	logic ord_we, pm_we, key_we, less;
	logic [CNT_W-1:0] qqs;
	logic [PARTS_W-1:0] rrs;
	logic [8:0] pnum;

	logic signed [KEY_W-1:0] xmem [MAX_CELLS];
	logic signed [KEY_W-1:0] ymem [MAX_CELLS];
	logic [CELL_W-1:0] omem [MAX_CELLS];
	logic [PART_W-1:0] pmem [MAX_CELLS];

	assign pxc = clamp_parts(px_q, PARTS_W'(MAX_PARTS_X));
	assign pyc = clamp_parts(py_q, PARTS_W'(MAX_PARTS_Y));

	assign s_tready = (state_q == S_IDLE) && !rd_pend_q && (!m_tvalid_q || m_tready);
	assign in_xfer  = s_tvalid && s_tready;
	assign ld_xfer  = in_xfer && (s_tuser == MODE_LOAD);
	assign q_xfer   = in_xfer && (s_tuser == MODE_QUERY);

	assign ce     = done_q ? '0 : count_q;
	assign key_we = ld_xfer && !ce[CNT_W-1];
	assign xsum = sext(s_tdata[31:0]) + sext(s_tdata[95:64]) + sext(s_tdata[159:128])
		+ sext(s_tdata[223:192]);
	assign ysum = sext(s_tdata[63:32]) + sext(s_tdata[127:96]) + sext(s_tdata[191:160])
		+ sext(s_tdata[255:224]);

	assign last_a = (a_q == n_q - CNT_W'(1));

	always_comb begin
		case (state_q)
			S_IDLE:                  rd_addr = s_tdata[265:256];
			S_XSCAN, S_YSCAN:        rd_addr = b_q[CELL_W-1:0];
			default:                 rd_addr = a_q[CELL_W-1:0];
		endcase
	end

	assign key_b = (state_q == S_YSCAN) ? yrd : xrd;
	always_comb begin
		less = (key_b < ka_q) || ((key_b == ka_q) && (b_s1 < a_q[CELL_W-1:0]));
		if (state_q == S_YSCAN) less = less && (ord_rd[SLICE_W-1:0] == sa_q);
	end

	assign dvs   = (dv_ph_q == 2'd0) ? pxc : pyc;
	assign nxt_s = st_q + POS_W'(qx_q) + POS_W'({1'b0, k_q} < rx_q);
	assign big   = ({1'b0, sa_q} < rx_q);
	assign qqs   = big ? qq1_q : qq0_q;
	assign rrs   = big ? rr1_q : rr0_q;
	assign nxt_p = st_q + POS_W'(qqs) + POS_W'({1'b0, k_q} < rrs);
	assign pnum  = 9'(sa_q) * 9'(pyc) + 9'(k_q);

	always_comb begin
		ord_we = 1'b0;
		ord_wd = cnt_q;
		pm_we  = 1'b0;
		case (state_q)
			S_XSCAN: ord_we = (b_q == n_q) && !v_s1;
			S_SSRCH: begin
				ord_we = (POS_W'(t_q) < nxt_s);
				ord_wd = CELL_W'(k_q);
			end
			S_PSRCH: pm_we = (POS_W'(cnt_q) < nxt_p);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			xmem[ce[CELL_W-1:0]] <= xsum;
			ymem[ce[CELL_W-1:0]] <= ysum;
		end
		xrd <= xmem[rd_addr];
		yrd <= ymem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ord_we) omem[a_q[CELL_W-1:0]] <= ord_wd;
		ord_rd <= omem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pm_we) pmem[a_q[CELL_W-1:0]] <= pnum[PART_W-1:0];
		pm_rd <= pmem[rd_addr];
	end

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PARTS_Y) ? {27'b0, py_q} : {27'b0, px_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= PARTS_W'(1);
			py_q <= PARTS_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_PARTS_X) px_q <= pwdata[PARTS_W-1:0];
			else py_q <= pwdata[PARTS_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			rd_pend_q  <= 1'b0;
		end else begin
			rd_pend_q <= q_xfer;
			if (rd_pend_q) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_xfer)
			pend_st_q <= !(done_q && ({1'b0, s_tdata[265:256]} < count_q));
		if (rd_pend_q) begin
			status_q <= pend_st_q ? STATUS_MISS : STATUS_OK;
			part_q   <= pend_st_q ? '0 : pm_rd;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = part_q;
	assign m_tuser  = status_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ld_xfer) begin
						count_q <= ce + CNT_W'(!ce[CNT_W-1]);
						done_q  <= 1'b0;
						if (s_tlast) begin
							n_q     <= ce + CNT_W'(!ce[CNT_W-1]);
							acc_q   <= ce + CNT_W'(!ce[CNT_W-1]);
							quo_q   <= '0;
							dv_ph_q <= 2'd0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (acc_q >= CNT_W'(dvs)) begin
						acc_q <= acc_q - CNT_W'(dvs);
						quo_q <= quo_q + CNT_W'(1);
					end else begin
						quo_q <= '0;
						case (dv_ph_q)
							2'd0: begin
								qx_q    <= quo_q;
								rx_q    <= acc_q[PARTS_W-1:0];
								acc_q   <= quo_q + CNT_W'(1);
								dv_ph_q <= 2'd1;
							end
							2'd1: begin
								qq1_q   <= quo_q;
								rr1_q   <= acc_q[PARTS_W-1:0];
								acc_q   <= qx_q;
								dv_ph_q <= 2'd2;
							end
							default: begin
								qq0_q   <= quo_q;
								rr0_q   <= acc_q[PARTS_W-1:0];
								a_q     <= '0;
								state_q <= S_XA;
							end
						endcase
					end
				end
				S_XA, S_YA: state_q <= (state_q == S_XA) ? S_XK : S_YK;
				S_XK, S_YK: begin
					ka_q  <= (state_q == S_XK) ? xrd : yrd;
					sa_q  <= ord_rd[SLICE_W-1:0];
					b_q   <= '0;
					cnt_q <= '0;
					v_s1  <= 1'b0;
					state_q <= (state_q == S_XK) ? S_XSCAN : S_YSCAN;
				end
				S_XSCAN, S_YSCAN: begin
					// issue one read a cycle, compare the previous one
					if (b_q < n_q) begin
						b_s1 <= b_q[CELL_W-1:0];
						v_s1 <= 1'b1;
						b_q  <= b_q + CNT_W'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && less) cnt_q <= cnt_q + CELL_W'(1);
					if ((b_q == n_q) && !v_s1) begin
						if (state_q == S_XSCAN) begin
							if (last_a) begin
								a_q     <= '0;
								state_q <= S_SA;
							end else begin
								a_q     <= a_q + CNT_W'(1);
								state_q <= S_XA;
							end
						end else begin
							k_q     <= '0;
							st_q    <= '0;
							state_q <= S_PSRCH;
						end
					end
				end
				S_SA: state_q <= S_SL;
				S_SL: begin
					t_q     <= ord_rd;
					k_q     <= '0;
					st_q    <= '0;
					state_q <= S_SSRCH;
				end
				S_SSRCH: begin
					if (POS_W'(t_q) < nxt_s) begin
						if (last_a) begin
							a_q     <= '0;
							state_q <= S_YA;
						end else begin
							a_q     <= a_q + CNT_W'(1);
							state_q <= S_SA;
						end
					end else begin
						st_q <= nxt_s;
						k_q  <= k_q + SLICE_W'(1);
					end
				end
				S_PSRCH: begin
					if (POS_W'(cnt_q) < nxt_p) begin
						if (last_a) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							a_q     <= a_q + CNT_W'(1);
							state_q <= S_YA;
						end
					end else begin
						st_q <= nxt_p;
						k_q  <= k_q + SLICE_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_xfer |=> ##1 m_tvalid)
		else $error("query transfer gave no result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CELLS))
		else $error("cell count beyond store depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> (state_q == S_IDLE))
		else $error("run finished outside idle");

endmodule

// ----- test/two_level_coordinate_partition_top_tb.sv -----
`timescale 1ns / 1ps
// Stream testbench for the two-level coordinate partitioner: load runs and queries
// checked against an in-bench partition predictor. Depends on tcp_pkg and the top level.
module two_level_coordinate_partition_top_tb;
	import tcp_pkg::*;

	typedef struct {
		logic              mode;
		logic [31:0]       vert [8];
		logic [CELL_W-1:0] qcell;
		logic              last;
		bit                drain_first;
	} cell_item_t;

	typedef struct {
		logic [PART_W-1:0] part;
		logic              status;
	} part_result_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser, s_tlast;
	logic [271:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [7:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	two_level_coordinate_partition_top dut (.*);

	cell_item_t   pending_items [$];
	part_result_t expected_parts [$];
	int  fail_count = 0;
	int  cycle_count = 0;
	int  stall_cycles = 0;

	// predictor state
	logic signed [KEY_W-1:0] x_sum [MAX_CELLS];
	logic signed [KEY_W-1:0] y_sum [MAX_CELLS];
	logic [CELL_W-1:0]       rank_order [MAX_CELLS];
	logic [PART_W-1:0]       cell_part [MAX_CELLS];
	int unsigned             cells_loaded = 0;
	bit                      run_done = 0;
	logic [PARTS_W-1:0]      slices_cfg = 1, pieces_cfg = 1;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit goes_first(int a, int b, bit on_y);
		logic signed [KEY_W-1:0] ka, kb;
		ka = on_y ? y_sum[a] : x_sum[a];
		kb = on_y ? y_sum[b] : x_sum[b];
		if (ka != kb) return ka < kb;
		return a < b;
	endfunction

	task automatic sort_span(int lo, int hi, bit on_y);
		int j;
		logic [CELL_W-1:0] v;
		for (int i = lo + 1; i < hi; i++) begin
			v = rank_order[i];
			j = i;
			while (j > lo && goes_first(v, rank_order[j-1], on_y)) begin
				rank_order[j] = rank_order[j-1];
				j--;
			end
			rank_order[j] = v;
		end
	endtask

	function automatic int span_start(int n, int p, int k);
		int r;
		r = n % p;
		return k * (n / p) + (k < r ? k : r);
	endfunction

	function automatic int clamped(int v, int mx);
		if (v < 1) return 1;
		return v > mx ? mx : v;
	endfunction

	task automatic assign_partitions();
		int px, py, n, s0, s1, p0, p1;
		px = clamped(slices_cfg, MAX_PARTS_X);
		py = clamped(pieces_cfg, MAX_PARTS_Y);
		n = cells_loaded;
		for (int i = 0; i < n; i++) rank_order[i] = CELL_W'(i);
		sort_span(0, n, 0);
		for (int i = 0; i < px; i++) begin
			s0 = span_start(n, px, i);
			s1 = span_start(n, px, i + 1);
			sort_span(s0, s1, 1);
			for (int j = 0; j < py; j++) begin
				p0 = s0 + span_start(s1 - s0, py, j);
				p1 = s0 + span_start(s1 - s0, py, j + 1);
				for (int k = p0; k < p1; k++)
					cell_part[rank_order[k]] = PART_W'(i * py + j);
			end
		end
		run_done = 1;
	endtask

	task automatic predict_item(cell_item_t it);
		part_result_t r;
		if (it.mode == MODE_LOAD) begin
			if (run_done) begin
				run_done = 0;
				cells_loaded = 0;
			end
			if (cells_loaded < MAX_CELLS) begin
				x_sum[cells_loaded] = sext(it.vert[0]) + sext(it.vert[2]) + sext(it.vert[4])
					+ sext(it.vert[6]);
				y_sum[cells_loaded] = sext(it.vert[1]) + sext(it.vert[3]) + sext(it.vert[5])
					+ sext(it.vert[7]);
				cells_loaded++;
			end
			if (it.last) assign_partitions();
		end else begin
			if (run_done && it.qcell < cells_loaded) begin
				r.part = cell_part[it.qcell];
				r.status = STATUS_OK;
			end else begin
				r.part = '0;
				r.status = STATUS_MISS;
			end
			expected_parts.push_back(r);
		end
	endtask

	function automatic bit calm_window();
		return (cycle_count % 5000) < 800;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		cell_item_t cur, nxt;
		bit send;
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tuser <= 0;
			s_tlast <= 0;
		end else begin
			cycle_count++;
			if (s_tvalid && s_tready) predict_item(cur);
			if (!s_tvalid || s_tready) begin
				send = pending_items.size() > 0
					&& (calm_window() || $urandom_range(99) >= 34);
				if (send && pending_items[0].drain_first && expected_parts.size() > 0)
					send = 0;
				if (send) begin
					nxt = pending_items.pop_front();
					cur = nxt;
					s_tdata <= {6'b0, nxt.qcell, nxt.vert[7], nxt.vert[6], nxt.vert[5],
						nxt.vert[4], nxt.vert[3], nxt.vert[2], nxt.vert[1], nxt.vert[0]};
					s_tuser <= nxt.mode;
					s_tlast <= nxt.last;
				end
				s_tvalid <= send;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		part_result_t e;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_parts.size() == 0) begin
					$display("%0t: result with none expected: part %0d status %0d",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					e = expected_parts.pop_front();
					if (m_tdata !== e.part) begin
						$display("%0t: partition expected %0d actual %0d",
							$time, e.part, m_tdata);
						fail_count++;
					end
					if (m_tuser !== e.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, e.status, m_tuser);
						fail_count++;
					end
				end
			end
			m_tready <= calm_window() || $urandom_range(99) >= 34;
		end
	end

	// watchdog: partitioning a run stalls the input for a while, so allow plenty
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 200000) begin
			$display("FAIL two_level_coordinate_partition_top");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		if (addr == 3'd0) slices_cfg = val[PARTS_W-1:0];
		else if (addr == 3'd4) pieces_cfg = val[PARTS_W-1:0];
	endtask

	task automatic set_parts(int px, int py);
		write_reg(3'd0, px);
		write_reg(3'd4, py);
	endtask

	task automatic add_load(logic [31:0] vx, logic [31:0] vy, bit last, bit spread);
		cell_item_t it;
		it.mode = MODE_LOAD;
		for (int i = 0; i < 8; i++)
			it.vert[i] = spread ? $urandom : ((i % 2) ? vy : vx);
		it.qcell = CELL_W'($urandom);
		it.last = last;
		it.drain_first = 0;
		pending_items.push_back(it);
	endtask

	task automatic add_query(int qc, bit drain);
		cell_item_t it;
		it.mode = MODE_QUERY;
		for (int i = 0; i < 8; i++) it.vert[i] = $urandom;
		it.qcell = CELL_W'(qc);
		it.last = 1'($urandom_range(1));
		it.drain_first = drain;
		pending_items.push_back(it);
	endtask

	task automatic finish_phase();
		while (pending_items.size() > 0 || s_tvalid || expected_parts.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int n, nq, total;
		logic [31:0] base;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// queries before any run, then a run with extreme coordinates and ties
		add_query(0, 0);
		add_query(1023, 0);
		add_load(32'h8000_0000, 32'h7fff_ffff, 0, 0);
		add_load(32'h7fff_ffff, 32'h8000_0000, 0, 0);
		add_load(32'h0, 32'h0, 0, 0);
		add_query(0, 1);
		add_load(32'h0, 32'h0, 0, 0);
		add_load(32'hffff_ffff, 32'h0001_0000, 1, 0);
		for (int c = 0; c < 7; c++) add_query(c, c == 0);
		add_query(1023, 0);
		finish_phase();

		set_parts(0, 31);
		for (int c = 0; c < 6; c++) add_load(32'h10 * (c % 3), 32'h5, c == 5, 0);
		for (int c = 0; c < 7; c++) add_query(c, 0);
		finish_phase();

		set_parts(16, 16);
		total = 40;
		for (int c = 0; c < 3; c++) add_load(0, 0, c == 2, 1);
		for (int c = 0; c < 4; c++) add_query(c, 0);
		finish_phase();

		while (total < 550) begin
			set_parts($urandom_range(31), $urandom_range(31));
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 20);
			base = $urandom;
			for (int c = 0; c < n; c++) begin
				if ($urandom_range(7) == 0) add_query($urandom_range(n), 0);
				if ($urandom_range(2) == 0)
					add_load(base + $urandom_range(3), base + $urandom_range(3),
						c == n - 1, 0);
				else
					add_load(0, 0, c == n - 1, 1);
			end
			nq = $urandom_range(5, 15);
			for (int c = 0; c < nq; c++)
				add_query(($urandom_range(9) == 0) ? $urandom_range(1023)
					: $urandom_range(n + 2), $urandom_range(19) == 0);
			total += n + nq;
			finish_phase();
		end

		finish_phase();
		if (fail_count == 0)
			$display("PASS two_level_coordinate_partition_top");
		else
			$display("FAIL two_level_coordinate_partition_top");
		$finish;
	end
endmodule
